[rtl/cstr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cstr_pkg;

  // default geometry
  localparam int CHAR_COUNT_DEF = 256;
  localparam int IMAGE_SIDE_DEF = 128;

  // configuration register indexes
  localparam logic [1:0] CFG_MASK_LAYOUT   = 2'd0;
  localparam logic [1:0] CFG_COLOUR_LAYOUT = 2'd1;

  // mask layout codes
  localparam logic [1:0] MASK_NONE   = 2'd0;
  localparam logic [1:0] MASK_BEFORE = 2'd1;
  localparam logic [1:0] MASK_AFTER  = 2'd2;

  // colour layout codes
  localparam logic [1:0] COL_NONE   = 2'd0;
  localparam logic [1:0] COL_LEAD   = 2'd1;
  localparam logic [1:0] COL_TAIL   = 2'd2;
  localparam logic [1:0] COL_LOOKUP = 2'd3;

  // colours
  localparam logic [7:0]  ATTR_DEFAULT = 8'hFF;
  localparam logic [31:0] OPAQUE_BLACK = 32'hFF000000;
  localparam logic [31:0] WHITE        = 32'hFFFFFFFF;
  localparam logic [31:0] TRANSPARENT  = 32'h00000000;
  localparam logic [31:0] DIM_MASK     = 32'hFFD7D7D7;

  typedef struct packed {
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [7:0]  pixel_bits;
    logic [31:0] ink_colour;
    logic [31:0] paper_colour;
    logic [7:0]  write_mask;
    logic        last_row;
  } row_item_t;

  // palette entry, dimmed unless bright
  function automatic logic [31:0] shade(input logic [2:0] code, input logic bright);
    logic [31:0] c;
    unique case (code)
      3'd0:    c = 32'hFF000000;
      3'd1:    c = 32'hFFFF0000;
      3'd2:    c = 32'hFF0000FF;
      3'd3:    c = 32'hFFFF00FF;
      3'd4:    c = 32'hFF00FF00;
      3'd5:    c = 32'hFFFFFF00;
      3'd6:    c = 32'hFF00FFFF;
      default: c = 32'hFFFFFFFF;
    endcase
    return bright ? c : (c & DIM_MASK);
  endfunction

endpackage

`default_nettype wire

[rtl/cstr_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cstr_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/cstr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module cstr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/char_set_tile_renderer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Character set tile renderer.
// byte_in carries the character set one byte per transaction, in record order:
// optional leading attribute, eight pixel rows each with an optional mask byte
// before or after it, optional trailing attribute. row_out carries one
// transaction per 8-pixel row; eight of them follow every completed record,
// cells filling a grid left to right, then top to bottom.
// Configuration goes through cfg_we / cfg_index / cfg_data; a write restarts
// the current record.
// Throughput: one byte per cycle while byte_in is ready, one row per cycle while
// row_out is not stalled. Pixel rows sit in a two-bank row RAM (one bank filling,
// one draining), so the eight rows of a record drain while the next record fills.
// A completed record marks its bank pending; its rows are then read from the RAM
// (registered read) and pass through the output register.
// When the receiver stalls, the drain holds in a two-entry output stage; byte_in
// drops ready only once both banks hold records still waiting to drain.
// Reset empties both banks and the output stage, restarts at cell zero and sets
// the attribute to white ink on transparent paper.

module char_set_tile_renderer #(
  parameter int CHAR_COUNT = cstr_pkg::CHAR_COUNT_DEF,
  parameter int IMAGE_SIDE = cstr_pkg::IMAGE_SIDE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data,
  cstr_stream_if.sink     byte_in,
  cstr_stream_if.source   row_out
);

  localparam int CIDX_W = $clog2(CHAR_COUNT);
  localparam int COLS   = IMAGE_SIDE / 8;
  localparam logic [6:0]        LAST_X    = 7'((COLS - 1) * 8);
  localparam logic [7:0]        SIDE      = 8'(IMAGE_SIDE);
  localparam logic [CIDX_W-1:0] LAST_CHAR = CIDX_W'(CHAR_COUNT - 1);

  typedef struct packed {
    logic [6:0]  x;
    logic [6:0]  ybase;
    logic [31:0] ink;
    logic [31:0] paper;
  } cell_meta_t;

  // configuration and record state
  logic [1:0]        mask_layout;
  logic [1:0]        colour_layout;
  logic [4:0]        record_position;
  logic [7:0]        attribute_byte;
  logic [CIDX_W-1:0] char_index;
  logic [6:0]        cell_x;
  logic [6:0]        cell_ybase;

  // bank control
  logic [1:0] pending;
  logic       wb;
  logic       rb;
  logic [2:0] rrow;
  cell_meta_t bank_meta [2];

  // read and output stages
  logic       dv;
  logic       d_bank;
  logic [2:0] d_row;
  logic [7:0] ram_rdata;
  logic       ov;
  logic       sv;
  cstr_pkg::row_item_t out_item;
  cstr_pkg::row_item_t skid_item;
  cstr_pkg::row_item_t new_item;

  // record decode
  logic       masked;
  logic       lead;
  logic       tail;
  logic [4:0] rec_len;
  logic [4:0] pos;
  logic [4:0] q;
  logic       in_rows;
  logic       is_pixel;
  logic       is_attr;
  logic [2:0] row;
  logic       last_byte;
  logic       accept;
  logic       cfg_hit;
  logic       rec_done;
  logic [7:0] attr_eff;
  logic [31:0] ink_new;
  logic [31:0] paper_new;
  logic [7:0] data;

  assign data    = byte_in.payload.data_byte;
  assign accept  = byte_in.valid && byte_in.ready;
  assign cfg_hit = cfg_we &&
                   (cfg_index == cstr_pkg::CFG_MASK_LAYOUT ||
                    cfg_index == cstr_pkg::CFG_COLOUR_LAYOUT);

  // position within the record and what the byte is
  always_comb begin
    masked  = (mask_layout == cstr_pkg::MASK_BEFORE) ||
              (mask_layout == cstr_pkg::MASK_AFTER);
    lead    = (colour_layout == cstr_pkg::COL_LEAD);
    tail    = (colour_layout == cstr_pkg::COL_TAIL) ||
              (colour_layout == cstr_pkg::COL_LOOKUP);
    rec_len = {4'd0, lead} + (masked ? 5'd16 : 5'd8) + {4'd0, tail};
    pos     = (record_position >= rec_len) ? 5'd0 : record_position;
    q       = pos - {4'd0, lead};
    in_rows = !(lead && pos == 5'd0) && (q < (masked ? 5'd16 : 5'd8));
    row     = masked ? q[3:1] : q[2:0];
    is_pixel = in_rows &&
               (!masked || ((mask_layout == cstr_pkg::MASK_BEFORE) ? q[0] : !q[0]));
    is_attr  = !in_rows;
    last_byte = (5'(pos + 5'd1) == rec_len);
  end

  assign rec_done = accept && last_byte;

  // colours for the completed record
  always_comb begin
    if (colour_layout == cstr_pkg::COL_NONE) begin
      attr_eff = cstr_pkg::ATTR_DEFAULT;
    end else begin
      attr_eff = is_attr ? data : attribute_byte;
    end
    if (attr_eff == cstr_pkg::ATTR_DEFAULT) begin
      ink_new   = cstr_pkg::WHITE;
      paper_new = cstr_pkg::TRANSPARENT;
    end else begin
      ink_new   = cstr_pkg::shade(attr_eff[2:0], attr_eff[6]);
      paper_new = cstr_pkg::shade(attr_eff[5:3], attr_eff[6]);
    end
  end

  assign byte_in.ready = !pending[wb];

  // configuration, record position and attribute
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_layout     <= cstr_pkg::MASK_NONE;
      colour_layout   <= cstr_pkg::COL_NONE;
      record_position <= 5'd0;
      attribute_byte  <= cstr_pkg::ATTR_DEFAULT;
    end else begin
      if (cfg_we && cfg_index == cstr_pkg::CFG_MASK_LAYOUT) begin
        mask_layout <= cfg_data;
      end
      if (cfg_we && cfg_index == cstr_pkg::CFG_COLOUR_LAYOUT) begin
        colour_layout <= cfg_data;
      end
      if (cfg_hit) begin
        record_position <= 5'd0;
      end else if (accept) begin
        record_position <= last_byte ? 5'd0 : 5'(pos + 5'd1);
      end
      if (accept && is_attr) begin
        attribute_byte <= data;
      end
    end
  end

  // cell position, advanced per completed record
  always_ff @(posedge clk) begin
    logic [7:0] ysum;
    if (rst) begin
      char_index <= '0;
      cell_x     <= 7'd0;
      cell_ybase <= 7'd0;
    end else if (rec_done) begin
      ysum = {1'b0, cell_ybase} + 8'd8;
      if (char_index == LAST_CHAR) begin
        char_index <= '0;
        cell_x     <= 7'd0;
        cell_ybase <= 7'd0;
      end else begin
        char_index <= char_index + CIDX_W'(1);
        if (cell_x == LAST_X) begin
          cell_x     <= 7'd0;
          cell_ybase <= (ysum >= SIDE) ? 7'(ysum - SIDE) : 7'(ysum);
        end else begin
          cell_x <= cell_x + 7'd8;
        end
      end
    end
  end

  // per-bank cell data, captured at record completion
  always_ff @(posedge clk) begin
    if (rec_done) begin
      bank_meta[wb] <= '{x: cell_x, ybase: cell_ybase, ink: ink_new, paper: paper_new};
    end
  end

  // drain issue: only while the output stage has room for the read in flight
  logic       pop;
  logic [1:0] occ_after;
  logic       issue;

  assign pop       = ov && row_out.ready;
  assign occ_after = 2'({1'b0, ov} + {1'b0, sv} + {1'b0, dv} - {1'b0, pop});
  assign issue     = pending[rb] && (occ_after < 2'd2);

  // row RAM, two banks of eight rows
  cstr_ram #(
    .WIDTH (8),
    .DEPTH (16)
  ) u_row_ram (
    .clk   (clk),
    .we    (accept && is_pixel),
    .waddr ({wb, row}),
    .wdata (data),
    .re    (issue),
    .raddr ({rb, rrow}),
    .rdata (ram_rdata)
  );

  // bank hand-over between filling and draining
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'b00;
      wb      <= 1'b0;
      rb      <= 1'b0;
      rrow    <= 3'd0;
      dv      <= 1'b0;
    end else begin
      if (rec_done) begin
        pending[wb] <= 1'b1;
        wb          <= !wb;
      end
      if (issue) begin
        rrow <= rrow + 3'd1;
        if (rrow == 3'd7) begin
          pending[rb] <= 1'b0;
          rb          <= !rb;
        end
      end
      dv <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      d_bank <= rb;
      d_row  <= rrow;
    end
  end

  // assemble the row transaction from RAM data and bank data
  always_comb begin
    cell_meta_t m;
    logic [7:0] ysum;
    logic [7:0] wm;
    m    = bank_meta[d_bank];
    ysum = {1'b0, m.ybase} + {5'd0, d_row};
    wm   = 8'd0;
    if (m.ink != cstr_pkg::OPAQUE_BLACK) begin
      wm = wm | ram_rdata;
    end
    if (m.paper != cstr_pkg::OPAQUE_BLACK) begin
      wm = wm | ~ram_rdata;
    end
    new_item.pixel_x      = m.x;
    new_item.pixel_y      = (ysum >= SIDE) ? 7'(ysum - SIDE) : 7'(ysum);
    new_item.pixel_bits   = ram_rdata;
    new_item.ink_colour   = m.ink;
    new_item.paper_colour = m.paper;
    new_item.write_mask   = wm;
    new_item.last_row     = (d_row == 3'd7);
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (!ov || pop) begin
        ov <= sv || dv;
      end
      if (sv) begin
        if (pop) begin
          sv <= dv;
        end
      end else if (dv && ov && !pop) begin
        sv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || pop) begin
      if (sv) begin
        out_item <= skid_item;
      end else if (dv) begin
        out_item <= new_item;
      end
    end
    if (dv && ((sv && pop) || (!sv && ov && !pop))) begin
      skid_item <= new_item;
    end
  end

  assign row_out.valid   = ov;
  assign row_out.payload = out_item;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry held without output entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) (sv && dv) |-> pop)
    else $error("row arrived with output stage full");

  a_drain_bank_pending: assert property (@(posedge clk) disable iff (rst)
    (rb != wb) |-> pending[rb])
    else $error("drain bank differs from fill bank but holds no record");

  a_both_pending_same: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'b11) |-> (rb == wb))
    else $error("both banks pending with mismatched pointers");

  a_done_free_bank: assert property (@(posedge clk) disable iff (rst)
    rec_done |=> pending[!wb])
    else $error("completed record not marked for drain");

endmodule

`default_nettype wire
